// ===== sv/bcls_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and limits for the button press classifier.
// No dependencies; imported by every module of the block.
package bcls_pkg;

   localparam int unsigned LIMIT_W          = 20;
   localparam int unsigned HOLD_W           = 9;
   localparam int unsigned PHASE_W          = 3;
   localparam int unsigned EVENT_W          = 3;
   localparam int unsigned CSR_ADDR_W       = 5;
   localparam int unsigned CSR_DATA_W       = 32;
   localparam int unsigned CSR_INDEX_W      = 3;

   localparam int unsigned HOLD_CAP_TICKS   = 300;
   localparam int unsigned LONG_PRESS_TICKS = 80;
   localparam logic [HOLD_W-1:0] HOLD_CAP   = HOLD_W'(HOLD_CAP_TICKS);
   localparam logic [HOLD_W-1:0] LONG_PRESS = HOLD_W'(LONG_PRESS_TICKS);

   // phases
   localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_WAIT   = 3'd1;
   localparam logic [PHASE_W-1:0] PH_OK     = 3'd2;
   localparam logic [PHASE_W-1:0] PH_CANCEL = 3'd3;
   localparam logic [PHASE_W-1:0] PH_UP     = 3'd4;
   localparam logic [PHASE_W-1:0] PH_DOWN   = 3'd5;

   // event codes
   localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
   localparam logic [EVENT_W-1:0] EV_OK      = 3'd1;
   localparam logic [EVENT_W-1:0] EV_OK_LONG = 3'd2;
   localparam logic [EVENT_W-1:0] EV_CANCEL  = 3'd3;
   localparam logic [EVENT_W-1:0] EV_UP      = 3'd4;
   localparam logic [EVENT_W-1:0] EV_DOWN    = 3'd5;

   // function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // press modes
   localparam logic [1:0] MODE_NONE   = 2'd0;
   localparam logic [1:0] MODE_SINGLE = 2'd1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PRESS_MODE     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ACTIVE_LOW     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OK_PRESENT     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CANCEL_PRESENT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_UP_PRESENT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_DOWN_PRESENT   = 3'd5;

   typedef struct packed {
      logic [1:0] press_mode;
      logic       active_low;
      logic       ok_present;
      logic       cancel_present;
      logic       up_present;
      logic       down_present;
   } cfg_type;

   typedef struct packed {
      logic               func;
      logic [LIMIT_W-1:0] timeout_ticks;
      logic               ok_level;
      logic               cancel_level;
      logic               up_level;
      logic               down_level;
   } req_type;

   typedef struct packed {
      logic               emit;
      logic [EVENT_W-1:0] event_res;
      logic               ready_res;
   } step_out_type;

endpackage

// ===== sv/bcls_csr.sv =====
`timescale 1ns / 1ps
// Configuration registers behind an APB-style port.
// Depends on bcls_pkg for register indexes and the cfg_type struct.
module bcls_csr import bcls_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic [CSR_INDEX_W-1:0] index;
   logic                   wr_en;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_PRESS_MODE:     cfg_in.press_mode     = csr_pwdata[1:0];
            REG_ACTIVE_LOW:     cfg_in.active_low     = csr_pwdata[0];
            REG_OK_PRESENT:     cfg_in.ok_present     = csr_pwdata[0];
            REG_CANCEL_PRESENT: cfg_in.cancel_present = csr_pwdata[0];
            REG_UP_PRESENT:     cfg_in.up_present     = csr_pwdata[0];
            REG_DOWN_PRESENT:   cfg_in.down_present   = csr_pwdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_PRESS_MODE:     csr_prdata = CSR_DATA_W'(cfg_ff.press_mode);
         REG_ACTIVE_LOW:     csr_prdata = CSR_DATA_W'(cfg_ff.active_low);
         REG_OK_PRESENT:     csr_prdata = CSR_DATA_W'(cfg_ff.ok_present);
         REG_CANCEL_PRESENT: csr_prdata = CSR_DATA_W'(cfg_ff.cancel_present);
         REG_UP_PRESENT:     csr_prdata = CSR_DATA_W'(cfg_ff.up_present);
         REG_DOWN_PRESENT:   csr_prdata = CSR_DATA_W'(cfg_ff.down_present);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_mode     <= MODE_NONE;
         cfg_ff.active_low     <= 1'b1;
         cfg_ff.ok_present     <= 1'b0;
         cfg_ff.cancel_present <= 1'b0;
         cfg_ff.up_present     <= 1'b0;
         cfg_ff.down_present   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/bcls_step.sv =====
`timescale 1ns / 1ps
// Wait and hold state plus the per-word classification logic.
// Depends on bcls_pkg for phase and event codes and the shared structs.
module bcls_step import bcls_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_type      req,
   input  cfg_type      cfg,
   output step_out_type res
);

   logic [PHASE_W-1:0] phase_ff,   phase_in;
   logic [LIMIT_W-1:0] elapsed_ff, elapsed_in;
   logic [LIMIT_W-1:0] limit_ff,   limit_in;
   logic [HOLD_W-1:0]  hold_ff,    hold_in;
   logic [LIMIT_W-1:0] elapsed_inc;
   logic               ready;
   logic               p_ok, p_cancel, p_up, p_down;

   assign ready = (cfg.press_mode != MODE_NONE) & (cfg.ok_present | cfg.cancel_present);

   // a level that differs from active_low reads as pressed after the xor
   assign p_ok     = cfg.ok_present     & (req.ok_level     ^ cfg.active_low);
   assign p_cancel = cfg.cancel_present & (req.cancel_level ^ cfg.active_low);
   assign p_up     = cfg.up_present     & (req.up_level     ^ cfg.active_low);
   assign p_down   = cfg.down_present   & (req.down_level   ^ cfg.active_low);

   assign elapsed_inc = elapsed_ff + LIMIT_W'(1);

   always_comb begin
      phase_in      = phase_ff;
      elapsed_in    = elapsed_ff;
      limit_in      = limit_ff;
      hold_in       = hold_ff;
      res.emit      = 1'b0;
      res.event_res = EV_NONE;
      res.ready_res = ready;
      if (req.func == FUNC_START) begin
         if (!ready || req.timeout_ticks == '0) begin
            res.emit = 1'b1;
            phase_in = PH_IDLE;
         end else begin
            phase_in   = PH_WAIT;
            elapsed_in = '0;
            limit_in   = req.timeout_ticks;
            hold_in    = '0;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
            PH_WAIT: begin
               if (p_ok) begin
                  phase_in = PH_OK;
                  hold_in  = HOLD_W'(1);
               end else if (p_cancel) begin
                  phase_in = PH_CANCEL;
               end else if (p_up) begin
                  phase_in = PH_UP;
               end else if (p_down) begin
                  phase_in = PH_DOWN;
               end else begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc >= limit_ff) begin
                     res.emit = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
            end
            PH_OK: begin
               if (p_ok && hold_ff < HOLD_CAP) begin
                  hold_in = hold_ff + HOLD_W'(1);
               end else begin
                  res.emit = 1'b1;
                  phase_in = PH_IDLE;
                  if (cfg.press_mode == MODE_SINGLE) begin
                     res.event_res = (hold_ff >= LONG_PRESS) ? EV_OK_LONG : EV_CANCEL;
                  end else begin
                     res.event_res = EV_OK;
                  end
               end
            end
            PH_CANCEL: begin
               if (!p_cancel) begin
                  res.emit      = 1'b1;
                  res.event_res = EV_CANCEL;
                  phase_in      = PH_IDLE;
               end
            end
            PH_UP: begin
               if (!p_up) begin
                  res.emit      = 1'b1;
                  res.event_res = EV_UP;
                  phase_in      = PH_IDLE;
               end
            end
            PH_DOWN: begin
               if (!p_down) begin
                  res.emit      = 1'b1;
                  res.event_res = EV_DOWN;
                  phase_in      = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         elapsed_ff <= '0;
         limit_ff   <= '0;
         hold_ff    <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         limit_ff   <= limit_in;
         hold_ff    <= hold_in;
      end
   end

endmodule

// ===== sv/button_press_classifier.sv =====
`timescale 1ns / 1ps
// Top level of the button press classifier: input register, step logic, result register.
// Depends on bcls_pkg, bcls_csr and bcls_step.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | func, timeout_ticks, four button levels
//   rsp     | out       | rsp_valid/rsp_stall  | event_res, ready_res
//   csr     | in/out    | psel/penable/pready  | six configuration registers
//
// One word per cycle sustained while no result waits stalled. A word is held in the
// input register and is classified on its way into the result register.
// Words that produce no result leave no trace on rsp.
// req_stall rises only while the input register is full and a result waits stalled.
// Synchronous reset empties both registers and returns to the idle phase.
module button_press_classifier import bcls_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [LIMIT_W-1:0]    req_timeout_ticks,
   input  logic                  req_ok_level,
   input  logic                  req_cancel_level,
   input  logic                  req_up_level,
   input  logic                  req_down_level,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [EVENT_W-1:0]    rsp_event_res,
   output logic                  rsp_ready_res,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type            cfg;
   step_out_type       step_res;
   req_type            in_ff, in_in;
   logic               in_valid_ff, in_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [EVENT_W-1:0] event_ff, event_in;
   logic               ready_ff, ready_in;
   logic               accept;
   logic               advance;

   bcls_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   bcls_step u_step (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (in_ff),
      .cfg   (cfg),
      .res   (step_res)
   );

   // the held word moves on whenever the result slot is free or being drained
   assign advance   = in_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign in_in.func          = req_func;
   assign in_in.timeout_ticks = req_timeout_ticks;
   assign in_in.ok_level      = req_ok_level;
   assign in_in.cancel_level  = req_cancel_level;
   assign in_in.up_level      = req_up_level;
   assign in_in.down_level    = req_down_level;

   assign in_valid_in  = accept | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance ? step_res.emit : (rsp_valid_ff & rsp_stall);
   assign event_in     = step_res.event_res;
   assign ready_in     = step_res.ready_res;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = event_ff;
   assign rsp_ready_res = ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= in_in;
      end
      if (advance && step_res.emit) begin
         event_ff <= event_in;
         ready_ff <= ready_in;
      end
   end

endmodule

// ===== sv/bcls_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the button press classifier, bound to the top level.
// Depends on bcls_pkg for event codes.
module bcls_checker import bcls_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [EVENT_W-1:0] rsp_event_res,
   input logic               rsp_ready_res
);

   logic req_acc;

   assign req_acc = req_valid & ~req_stall;

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res) && $stable(rsp_ready_res))
      else $error("stalled result word changed");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // a fresh result must trace back to an accepted request word
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> $past(req_acc, 2))
      else $error("result word without an accepted request");

   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_res <= EV_DOWN))
      else $error("event code out of range");

endmodule

bind button_press_classifier bcls_checker u_bcls_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_event_res (rsp_event_res),
   .rsp_ready_res (rsp_ready_res)
);
